[hw/rtl/u2d_pkg.sv]
package u2d_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2,
    PH_DROP = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CL_ZERO,
    CL_ASCII,
    CL_LEAD2,
    CL_LEAD3,
    CL_CONT,
    CL_HIGH
  } byte_class_t;

  // classified byte: payload bits already masked for the class
  typedef struct packed {
    byte_class_t cls;
    logic [6:0]  data;
  } item_t;

  function automatic logic [COUNT_WIDTH-1:0] count_add2(input logic [COUNT_WIDTH-1:0] t);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, t} + (COUNT_WIDTH + 1)'(2);
    if (sum > {1'b0, COUNT_MAX}) begin
      return COUNT_MAX;
    end
    return sum[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [15:0] count_show(input logic [COUNT_WIDTH-1:0] t);
    logic [32:0] w;
    w = 33'(t);
    if (w > 33'h0FFFF) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

endpackage

[hw/rtl/u2d_front.sv]
module u2d_front
  import u2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] byte_in,
  output logic       item_valid,
  input  logic       item_ready,
  output item_t      item
);

  logic  vld;
  item_t cur;
  item_t cur_next;
  logic  take;

  assign take       = !vld || item_ready;
  assign byte_stall = !take;
  assign item_valid = vld;
  assign item       = cur;

  always_comb begin
    cur_next.data = 7'd0;
    if (byte_in == 8'h00) begin
      cur_next.cls = CL_ZERO;
    end else if (byte_in[7] == 1'b0) begin
      cur_next.cls  = CL_ASCII;
      cur_next.data = byte_in[6:0];
    end else if (byte_in[7:6] == 2'b10) begin
      cur_next.cls  = CL_CONT;
      cur_next.data = {1'b0, byte_in[5:0]};
    end else if (byte_in[7:5] == 3'b110) begin
      cur_next.cls  = CL_LEAD2;
      cur_next.data = {2'b00, byte_in[4:0]};
    end else if (byte_in[7:4] == 4'b1110) begin
      cur_next.cls  = CL_LEAD3;
      cur_next.data = {3'b000, byte_in[3:0]};
    end else begin
      cur_next.cls = CL_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && byte_valid) begin
      cur <= cur_next;
    end
  end

endmodule

[hw/rtl/u2d_queue.sv]
module u2d_queue
  import u2d_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  not_full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t                  mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]  wptr;
  logic [QPTR_WIDTH-1:0]  rptr;
  logic [QCNT_WIDTH-1:0]  count;
  logic                   do_push;
  logic                   do_pop;

  assign not_full  = count != QCNT_WIDTH'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rptr];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

[hw/rtl/u2d_back.sv]
module u2d_back
  import u2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_pop,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [15:0] code_unit,
  output logic [15:0] out_bytes
);

  phase_t                 phase, phase_next;
  logic [15:0]            partial, partial_next;
  logic [COUNT_WIDTH-1:0] total, total_next;
  logic                   ovld;
  logic                   emit;
  logic [1:0]             kind_next;
  logic [15:0]            code_next;
  logic [15:0]            bytes_next;
  logic                   step;

  assign step         = item_valid && (!ovld || !result_stall);
  assign item_pop     = step;
  assign result_valid = ovld;

  always_comb begin
    phase_next   = phase;
    partial_next = partial;
    total_next   = total;
    emit         = 1'b0;
    kind_next    = KIND_ERR;
    code_next    = 16'd0;
    bytes_next   = count_show(total);
    case (phase)
      PH_IDLE: begin
        case (item.cls)
          CL_ZERO: begin
            emit       = 1'b1;
            kind_next  = KIND_END;
            total_next = '0;
          end
          CL_ASCII: begin
            emit       = 1'b1;
            kind_next  = KIND_CHAR;
            code_next  = {9'd0, item.data};
            total_next = count_add2(total);
            bytes_next = count_show(total_next);
          end
          CL_LEAD2: begin
            partial_next = {5'd0, item.data[4:0], 6'd0};
            phase_next   = PH_ONE;
          end
          CL_LEAD3: begin
            partial_next = {item.data[3:0], 12'd0};
            phase_next   = PH_TWO;
          end
          default: begin
            emit         = 1'b1;
            partial_next = 16'd0;
            phase_next   = PH_DROP;
          end
        endcase
      end
      PH_TWO, PH_ONE: begin
        if (item.cls == CL_CONT) begin
          if (phase == PH_TWO) begin
            partial_next = partial | {4'd0, item.data[5:0], 6'd0};
            phase_next   = PH_ONE;
          end else begin
            emit         = 1'b1;
            kind_next    = KIND_CHAR;
            code_next    = partial | {10'd0, item.data[5:0]};
            total_next   = count_add2(total);
            bytes_next   = count_show(total_next);
            partial_next = 16'd0;
            phase_next   = PH_IDLE;
          end
        end else begin
          emit         = 1'b1;
          partial_next = 16'd0;
          if (item.cls == CL_ZERO) begin
            phase_next = PH_IDLE;
            total_next = '0;
          end else begin
            phase_next = PH_DROP;
          end
        end
      end
      default: begin
        if (item.cls == CL_ZERO) begin
          phase_next   = PH_IDLE;
          partial_next = 16'd0;
          total_next   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      partial <= 16'd0;
      total   <= '0;
      ovld    <= 1'b0;
    end else begin
      if (step) begin
        phase   <= phase_next;
        partial <= partial_next;
        total   <= total_next;
      end
      if (step) begin
        ovld <= emit;
      end else if (!result_stall) begin
        ovld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      kind      <= kind_next;
      code_unit <= code_next;
      out_bytes <= bytes_next;
    end
  end

endmodule

[hw/rtl/utf8_to_ucs2_decoder.sv]
// UTF-8 to UCS-2 decoder. Takes one byte of a zero-terminated string per beat and
// returns one beat per decoded character (kind 0), per end of string (kind 1, with the
// byte count of the string, two per character) and per malformed sequence (kind 2,
// after which bytes are dropped up to the next zero). Lead bytes and all but the last
// continuation byte of a character give no result. A byte registered by the classifying
// front end passes through a two-entry queue to the decode state machine, which takes
// one byte per clock while its output does not stall. Without stalls a byte passes the
// front end register and a queue entry before its result is registered at the output.
// Either side may stall without stopping the other until the queue fills.
module utf8_to_ucs2_decoder
  import u2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_in,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [15:0] code_unit,
  output logic [15:0] out_bytes
);

  logic  front_valid;
  logic  queue_not_full;
  logic  queue_not_empty;
  logic  back_pop;
  item_t front_item;
  item_t head_item;

  u2d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_in    (byte_in),
    .item_valid (front_valid),
    .item_ready (queue_not_full),
    .item       (front_item)
  );

  u2d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_item (front_item),
    .not_full  (queue_not_full),
    .pop       (back_pop),
    .not_empty (queue_not_empty),
    .head      (head_item)
  );

  u2d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (queue_not_empty),
    .item_pop     (back_pop),
    .item         (head_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .code_unit    (code_unit),
    .out_bytes    (out_bytes)
  );

endmodule

[test/utf8_decode_checker.sv]
`timescale 1ns / 100ps

module utf8_decode_checker
  import u2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  byte_in,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] code_unit,
  input  logic [15:0] out_bytes,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code;
    logic [15:0] nbytes;
  } decoded_t;

  decoded_t               pending_decodes[$];
  phase_t                 dec_phase;
  logic [15:0]            code_acc;
  logic [COUNT_WIDTH-1:0] string_bytes;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic logic [15:0] shown_count();
    longint unsigned t = 64'(string_bytes);
    return (t > 64'hFFFF) ? 16'hFFFF : t[15:0];
  endfunction

  task automatic push_decode(input logic [1:0] k, input logic [15:0] c);
    decoded_t d;
    d.kind = k;
    d.code = c;
    d.nbytes = shown_count();
    pending_decodes.push_back(d);
  endtask

  task automatic count_char();
    if (string_bytes >= COUNT_MAX - 1) begin
      string_bytes = COUNT_MAX;
    end else begin
      string_bytes = string_bytes + COUNT_WIDTH'(2);
    end
  endtask

  task automatic flag_malformed(input logic [7:0] b);
    push_decode(KIND_ERR, 16'h0000);
    code_acc = 16'h0000;
    if (b == 8'h00) begin
      dec_phase = PH_IDLE;
      string_bytes = '0;
    end else begin
      dec_phase = PH_DROP;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic cont;
    cont = (b[7:6] == 2'b10);
    case (dec_phase)
      PH_IDLE: begin
        if (b == 8'h00) begin
          push_decode(KIND_END, 16'h0000);
          string_bytes = '0;
        end else if (!b[7]) begin
          count_char();
          push_decode(KIND_CHAR, {8'h00, b});
        end else if (b[7:5] == 3'b110) begin
          code_acc = {5'b0, b[4:0], 6'b0};
          dec_phase = PH_ONE;
        end else if (b[7:4] == 4'b1110) begin
          code_acc = {b[3:0], 12'b0};
          dec_phase = PH_TWO;
        end else begin
          flag_malformed(b);
        end
      end
      PH_TWO: begin
        if (!cont) begin
          flag_malformed(b);
        end else begin
          code_acc[11:6] = b[5:0];
          dec_phase = PH_ONE;
        end
      end
      PH_ONE: begin
        if (!cont) begin
          flag_malformed(b);
        end else begin
          code_acc[5:0] = b[5:0];
          count_char();
          push_decode(KIND_CHAR, code_acc);
          code_acc = 16'h0000;
          dec_phase = PH_IDLE;
        end
      end
      default: begin
        if (b == 8'h00) begin
          dec_phase = PH_IDLE;
          code_acc = 16'h0000;
          string_bytes = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      dec_phase = PH_IDLE;
      code_acc = 16'h0000;
      string_bytes = '0;
      pending_decodes.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_decodes.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result kind=%0d code=%h bytes=%h",
                     $realtime, kind, code_unit, out_bytes);
          end
          mismatches++;
        end else begin
          want = pending_decodes.pop_front();
          if (kind !== want.kind || code_unit !== want.code ||
              out_bytes !== want.nbytes) begin
            if (mismatches < 10) begin
              $display({"%0t: result mismatch exp kind=%0d code=%h bytes=%h",
                        " got kind=%0d code=%h bytes=%h"},
                       $realtime, want.kind, want.code, want.nbytes,
                       kind, code_unit, out_bytes);
            end
            mismatches++;
          end
        end
      end
      if (byte_valid && !byte_stall) begin
        decode_byte(byte_in);
      end
    end
    outstanding = pending_decodes.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import u2d_pkg::*;

  localparam logic [7:0] OPENING[27] = '{
    8'h41, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80,
    8'hEF, 8'hBF, 8'hBF, 8'h00,
    8'hBF, 8'h41, 8'h00,
    8'hFF, 8'h00,
    8'hC3, 8'h41, 8'h00,
    8'hE2, 8'h00, 8'h00,
    8'hE2, 8'h82, 8'hC0
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  byte_in = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  kind;
  logic [15:0] code_unit;
  logic [15:0] out_bytes;

  int mismatches;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_armed = 1'b0;
  int hold_left = 0;

  utf8_to_ucs2_decoder uut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_in(byte_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .code_unit(code_unit),
    .out_bytes(out_bytes)
  );

  utf8_decode_checker u_checker (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_in(byte_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .code_unit(code_unit),
    .out_bytes(out_bytes),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when armed
  always @(posedge clk) begin
    if (hold_armed) begin
      hold_left = 400;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_in <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // one string, mostly well formed; some get a corrupted byte
  task automatic send_string(output int counted);
    logic [7:0] seq[$];
    int nchars;
    int sel;
    int pos;
    nchars = $urandom_range(12);
    for (int i = 0; i < nchars; i++) begin
      sel = $urandom_range(2);
      if (sel == 0) begin
        seq.push_back(8'($urandom_range(1, 127)));
      end else if (sel == 1) begin
        seq.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        seq.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
        seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
    end
    seq.push_back(8'h00);
    counted = seq.size();
    if ($urandom_range(99) < 15) begin
      pos = $urandom_range(seq.size() - 1);
      sel = $urandom_range(3);
      if (sel == 0) begin
        seq[pos] = 8'($urandom_range(255));
      end else if (sel == 1) begin
        seq[pos] = 8'($urandom_range(8'h80, 8'hBF));
      end else if (sel == 2) begin
        seq[pos] = 8'($urandom_range(8'hF0, 8'hFF));
      end else begin
        seq[pos] = 8'h00;
      end
      counted = pos + 1;
    end
    foreach (seq[j]) send_byte(seq[j]);
  endtask

  initial begin
    int n;
    int mode_items;
    int waited;
    longint sat_len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (OPENING[i]) send_byte(OPENING[i]);
    send_byte(8'h00);
    wait_drained();

    // one string long enough to saturate the byte count
    sat_len = (longint'(COUNT_MAX) + 1) / 2 + 4;
    for (longint i = 0; i < sat_len; i++) send_byte(8'($urandom_range(1, 127)));
    send_byte(8'h00);
    wait_drained();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      mode_items = 0;
      while (mode_items < 250) begin
        send_string(n);
        mode_items += n;
        if (mode == 0 && mode_items >= 100 && mode_items < 100 + n) begin
          // back up the output while the input keeps offering
          hold_armed = 1'b1;
          for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(1, 127)));
          send_byte(8'h00);
          wait_drained();
        end
      end
      if (mode == 2) begin
        wait_drained();
      end
    end

    byte_valid <= 1'b0;
    stall_pct = 0;
    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("utf8_to_ucs2_decoder regression: pass");
    end else begin
      $display("utf8_to_ucs2_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("utf8_to_ucs2_decoder regression: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/u2d_pkg.sv
hw/rtl/u2d_front.sv
hw/rtl/u2d_queue.sv
hw/rtl/u2d_back.sv
hw/rtl/utf8_to_ucs2_decoder.sv
test/utf8_decode_checker.sv
test/tb.sv
